>>> src/imu_frame_parser_top_defines.svh
// Assertion macros shared by the IMU frame parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef IMU_FRAME_PARSER_TOP_DEFINES_SVH
`define IMU_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ifp_pkg.sv
// Shared types and constants for the IMU frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package ifp_pkg;

   localparam int HELD_BYTES = 10;
   localparam int FILL_W     = 4;
   localparam int GAIN_W     = 32;
   localparam int RAW_W      = 16;
   localparam int AXIS_W     = 32;
   localparam int PROD_W     = RAW_W + GAIN_W + 1;
   localparam int SHIFT      = 15;

   localparam logic [7:0] FRAME_HEAD  = 8'h55;
   localparam logic [7:0] KIND_BYTE_A = 8'h51;
   localparam logic [7:0] KIND_BYTE_G = 8'h52;
   localparam logic [7:0] KIND_BYTE_R = 8'h53;
   localparam logic [7:0] KIND_BYTE_M = 8'h54;

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HELD_BYTES);

   typedef logic [1:0] frame_kind_type;
   localparam frame_kind_type KIND_ACCEL = 2'd0;
   localparam frame_kind_type KIND_GYRO  = 2'd1;
   localparam frame_kind_type KIND_MAG   = 2'd2;
   localparam frame_kind_type KIND_ANGLE = 2'd3;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_ACCEL_GAIN = 2'd0;
   localparam reg_index_type REG_GYRO_GAIN  = 2'd1;
   localparam reg_index_type REG_ANGLE_GAIN = 2'd2;
   localparam reg_index_type REG_MAG_GAIN   = 2'd3;

   localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 32'd10283148;
   localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = 32'd2287638;
   localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST = 32'd11796480;
   localparam logic [GAIN_W-1:0] MAG_GAIN_RST   = 32'd2147483648;

   typedef struct packed {
      logic [GAIN_W-1:0] accel;
      logic [GAIN_W-1:0] gyro;
      logic [GAIN_W-1:0] angle;
      logic [GAIN_W-1:0] mag;
   } gains_type;

   typedef struct packed {
      logic                    hit;
      frame_kind_type          kind;
      logic [RAW_W-1:0]        raw_x;
      logic [RAW_W-1:0]        raw_y;
      logic [RAW_W-1:0]        raw_z;
   } frame_type;

endpackage

`default_nettype wire

>>> src/ifp_csr.sv
// Gain register file behind the APB-style configuration port.
// Depends on ifp_pkg.
`default_nettype none

module ifp_csr
   import ifp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output gains_type        gains
);

   logic [GAIN_W-1:0] accel_ff, gyro_ff, angle_ff, mag_ff;
   reg_index_type     index;
   logic              write_en;

   assign index      = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= ACCEL_GAIN_RST;
         gyro_ff  <= GYRO_GAIN_RST;
         angle_ff <= ANGLE_GAIN_RST;
         mag_ff   <= MAG_GAIN_RST;
      end else if (write_en) begin
         case (index)
            REG_ACCEL_GAIN: accel_ff <= csr_pwdata;
            REG_GYRO_GAIN:  gyro_ff  <= csr_pwdata;
            REG_ANGLE_GAIN: angle_ff <= csr_pwdata;
            REG_MAG_GAIN:   mag_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_ACCEL_GAIN: csr_prdata = accel_ff;
         REG_GYRO_GAIN:  csr_prdata = gyro_ff;
         REG_ANGLE_GAIN: csr_prdata = angle_ff;
         REG_MAG_GAIN:   csr_prdata = mag_ff;
         default:        csr_prdata = '0;
      endcase
   end

   assign gains.accel = accel_ff;
   assign gains.gyro  = gyro_ff;
   assign gains.angle = angle_ff;
   assign gains.mag   = mag_ff;

endmodule

`default_nettype wire

>>> src/ifp_window.sv
// Ten-byte sliding window with header, kind and checksum test of each new byte.
// Depends on ifp_pkg and imu_frame_parser_top_defines.svh.
`default_nettype none

`include "imu_frame_parser_top_defines.svh"

module ifp_window
   import ifp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] rx_byte,
   output frame_type       frame
);

   logic [7:0]        window_ff [HELD_BYTES];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [7:0]        pair_sum [HELD_BYTES/2];
   logic [7:0]        sum;
   logic              known;
   frame_kind_type    kind;

   // Shift in every byte; after ten bytes the oldest sits at index zero.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < HELD_BYTES - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[HELD_BYTES-1] <= rx_byte;
      end
   end

   assign fill_in = (accept && fill_ff != FILL_FULL) ? fill_ff + 1'b1 : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_comb begin
      for (int i = 0; i < HELD_BYTES / 2; i++) begin
         pair_sum[i] = window_ff[2*i] + window_ff[2*i+1];
      end
   end

   assign sum = ((pair_sum[0] + pair_sum[1]) + (pair_sum[2] + pair_sum[3])) + pair_sum[4];

   always_comb begin
      known = 1'b1;
      case (window_ff[1])
         KIND_BYTE_A: kind = KIND_ACCEL;
         KIND_BYTE_G: kind = KIND_GYRO;
         KIND_BYTE_M: kind = KIND_MAG;
         KIND_BYTE_R: kind = KIND_ANGLE;
         default: begin
            kind  = KIND_ACCEL;
            known = 1'b0;
         end
      endcase
   end

   assign frame.hit   = accept && fill_ff == FILL_FULL && window_ff[0] == FRAME_HEAD
                        && known && sum == rx_byte;
   assign frame.kind  = kind;
   assign frame.raw_x = {window_ff[3], window_ff[2]};
   assign frame.raw_y = {window_ff[5], window_ff[4]};
   assign frame.raw_z = {window_ff[7], window_ff[6]};

   `IFP_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FILL_FULL, "fill count past window depth")
   `IFP_ASSERT_NOW(a_hit_full, frame.hit, fill_ff == FILL_FULL && accept,
      "frame hit before window filled")
   `IFP_ASSERT_NEXT(a_fill_step, accept && fill_ff != FILL_FULL,
      fill_ff == $past(fill_ff) + 1'b1, "fill count did not advance")

endmodule

`default_nettype wire

>>> src/ifp_scale.sv
// Gain multiply, product register, shift and saturation into the result register.
// Depends on ifp_pkg and imu_frame_parser_top_defines.svh.
`default_nettype none

`include "imu_frame_parser_top_defines.svh"

module ifp_scale
   import ifp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire frame_type    frame,
   input  wire gains_type    gains,
   output logic              stage_ready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output frame_kind_type    rsp_kind,
   output logic [AXIS_W-1:0] rsp_x,
   output logic [AXIS_W-1:0] rsp_y,
   output logic [AXIS_W-1:0] rsp_z
);

   localparam logic [AXIS_W-1:0] AXIS_MAX = {1'b0, {(AXIS_W-1){1'b1}}};
   localparam logic [AXIS_W-1:0] AXIS_MIN = {1'b1, {(AXIS_W-1){1'b0}}};

   logic [GAIN_W-1:0]        gain;
   logic signed [PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   frame_kind_type           kind_ff;
   logic                     prod_valid_ff;
   logic                     out_ready;
   logic                     out_load;
   logic                     rsp_valid_ff;
   frame_kind_type           rsp_kind_ff;
   logic [AXIS_W-1:0]        rsp_x_ff, rsp_y_ff, rsp_z_ff;

   function automatic logic [AXIS_W-1:0] saturate(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-SHIFT-1:0] q;
      logic [PROD_W-SHIFT-AXIS_W:0] top;
      q   = p[PROD_W-1:SHIFT];
      top = q[PROD_W-SHIFT-1:AXIS_W-1];
      if (top == '0 || top == '1) begin
         saturate = q[AXIS_W-1:0];
      end else if (q[PROD_W-SHIFT-1]) begin
         saturate = AXIS_MIN;
      end else begin
         saturate = AXIS_MAX;
      end
   endfunction

   always_comb begin
      case (frame.kind)
         KIND_ACCEL: gain = gains.accel;
         KIND_GYRO:  gain = gains.gyro;
         KIND_MAG:   gain = gains.mag;
         KIND_ANGLE: gain = gains.angle;
         default:    gain = gains.accel;
      endcase
   end

   assign prod_x_in = $signed(frame.raw_x) * $signed({1'b0, gain});
   assign prod_y_in = $signed(frame.raw_y) * $signed({1'b0, gain});
   assign prod_z_in = $signed(frame.raw_z) * $signed({1'b0, gain});

   assign out_ready   = !rsp_valid_ff || rsp_tready;
   assign stage_ready = !prod_valid_ff || out_ready;
   assign out_load    = prod_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (stage_ready) begin
         prod_valid_ff <= frame.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && frame.hit) begin
         kind_ff   <= frame.kind;
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= kind_ff;
         rsp_x_ff    <= saturate(prod_x_ff);
         rsp_y_ff    <= saturate(prod_y_ff);
         rsp_z_ff    <= saturate(prod_z_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_x      = rsp_x_ff;
   assign rsp_y      = rsp_y_ff;
   assign rsp_z      = rsp_z_ff;

   `IFP_ASSERT_NEXT(a_prod_hold, prod_valid_ff && !out_ready, prod_valid_ff,
      "product stage dropped a stalled transaction")
   `IFP_ASSERT_NEXT(a_prod_stable, prod_valid_ff && !out_ready, $stable(prod_x_ff),
      "product stage changed while stalled")
   `IFP_ASSERT_NOW(a_no_hit_stall, frame.hit, stage_ready,
      "frame hit while product stage full")

endmodule

`default_nettype wire

>>> src/imu_frame_parser_top.sv
// IMU frame parser: takes one serial byte per transaction on req_ and emits one
// result per valid 11-byte frame (0x55, kind 0x51..0x54, x/y/z little-endian,
// temperature, byte checksum) on rsp_, each axis scaled as (raw * gain) >>> 15
// and saturated to signed Q16.16. A byte is taken every cycle unless req_ is
// stalled; the gain multipliers register the product at the edge that accepts
// the checksum byte, and the shift and saturation register loads from it once
// the result register is free, which raises rsp_tvalid. Back-pressure on rsp_
// stops req_ only once both stages hold a frame.
// Gains are set through the csr_ port at byte addresses 0, 4, 8 and 12.
// Depends on ifp_pkg, ifp_csr, ifp_window and ifp_scale.
`default_nettype none

module imu_frame_parser_top
   import ifp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // [31:0] axis_x, [63:32] axis_y, [95:64] axis_z
   output logic [1:0]       rsp_tuser,   // [1:0] frame_kind
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   gains_type         gains;
   frame_type         frame;
   logic              accept;
   logic              stage_ready;
   frame_kind_type    rsp_kind;
   logic [AXIS_W-1:0] rsp_x, rsp_y, rsp_z;

   assign req_tready = stage_ready;
   assign accept     = req_tvalid && req_tready;

   ifp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   ifp_window u_window (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .frame   (frame)
   );

   ifp_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .frame       (frame),
      .gains       (gains),
      .stage_ready (stage_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_kind),
      .rsp_x       (rsp_x),
      .rsp_y       (rsp_y),
      .rsp_z       (rsp_z)
   );

   assign rsp_tdata = {rsp_z, rsp_y, rsp_x};
   assign rsp_tuser = rsp_kind;

endmodule

`default_nettype wire

>>> tb/imu_frame_parser_checker.sv
// Scoreboard for the IMU frame parser: watches the req_, rsp_ and csr_ channels,
// predicts each frame result from the accepted bytes and compares it field by field.
// Depends on ifp_pkg for widths, kind codes, frame bytes and gain reset values.

module imu_frame_parser_checker
   import ifp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          pending,
   output int          frames_checked
);

   typedef struct packed {
      frame_kind_type    kind;
      logic [AXIS_W-1:0] x;
      logic [AXIS_W-1:0] y;
      logic [AXIS_W-1:0] z;
   } axis_sample_type;

   axis_sample_type   expected_samples[$];
   axis_sample_type   want;
   logic [7:0]        rx_window[HELD_BYTES];
   logic [FILL_W-1:0] held_count;
   logic [GAIN_W-1:0] accel_gain, gyro_gain, angle_gain, mag_gain;

   initial begin
      failures = 0;
      pending = 0;
      frames_checked = 0;
   end

   // Floor of raw * gain / 2^15, clamped to the signed 32-bit range.
   function automatic logic [AXIS_W-1:0] scaled_axis(input logic [7:0] lo, input logic [7:0] hi,
                                                     input logic [GAIN_W-1:0] gain);
      longint prod;
      longint q;
      prod = longint'($signed({hi, lo})) * longint'({1'b0, gain});
      q = prod >>> SHIFT;
      if (q > 64'sd2147483647)
         q = 64'sd2147483647;
      if (q < -64'sd2147483648)
         q = -64'sd2147483648;
      return q[AXIS_W-1:0];
   endfunction

   task automatic parse_rx_byte(input logic [7:0] b);
      logic [7:0]        sum;
      logic [GAIN_W-1:0] gain;
      frame_kind_type    kind;
      logic              known;
      axis_sample_type   s;
      if (held_count < FILL_FULL) begin
         rx_window[held_count] = b;
         held_count = held_count + 1'b1;
         return;
      end
      sum = '0;
      for (int i = 0; i < HELD_BYTES; i++)
         sum = sum + rx_window[i];
      known = 1'b1;
      kind = KIND_ACCEL;
      gain = accel_gain;
      case (rx_window[1])
         KIND_BYTE_A: begin kind = KIND_ACCEL; gain = accel_gain; end
         KIND_BYTE_G: begin kind = KIND_GYRO;  gain = gyro_gain;  end
         KIND_BYTE_M: begin kind = KIND_MAG;   gain = mag_gain;   end
         KIND_BYTE_R: begin kind = KIND_ANGLE; gain = angle_gain; end
         default: known = 1'b0;
      endcase
      if (rx_window[0] == FRAME_HEAD && known && sum == b) begin
         s.kind = kind;
         s.x = scaled_axis(rx_window[2], rx_window[3], gain);
         s.y = scaled_axis(rx_window[4], rx_window[5], gain);
         s.z = scaled_axis(rx_window[6], rx_window[7], gain);
         expected_samples.push_back(s);
      end
      // slide the window by one byte
      for (int i = 0; i < HELD_BYTES - 1; i++)
         rx_window[i] = rx_window[i+1];
      rx_window[HELD_BYTES-1] = b;
   endtask

   task automatic check_field(input string name, input longint exp_val, input longint act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_samples.delete();
         for (int i = 0; i < HELD_BYTES; i++)
            rx_window[i] = '0;
         held_count = '0;
         accel_gain = ACCEL_GAIN_RST;
         gyro_gain = GYRO_GAIN_RST;
         angle_gain = ANGLE_GAIN_RST;
         mag_gain = MAG_GAIN_RST;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_ACCEL_GAIN: accel_gain = csr_pwdata;
               REG_GYRO_GAIN:  gyro_gain = csr_pwdata;
               REG_ANGLE_GAIN: angle_gain = csr_pwdata;
               REG_MAG_GAIN:   mag_gain = csr_pwdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected result transaction: kind %0d, tdata %h", rsp_tuser, rsp_tdata);
               failures++;
            end else begin
               want = expected_samples.pop_front();
               check_field("frame_kind", longint'(want.kind), longint'(rsp_tuser));
               check_field("axis_x", longint'($signed(want.x)), longint'($signed(rsp_tdata[31:0])));
               check_field("axis_y", longint'($signed(want.y)), longint'($signed(rsp_tdata[63:32])));
               check_field("axis_z", longint'($signed(want.z)), longint'($signed(rsp_tdata[95:64])));
               frames_checked++;
            end
         end
         if (req_tvalid && req_tready)
            parse_rx_byte(req_tdata);
      end
      pending = expected_samples.size();
   end

endmodule

>>> tb/tb_top.sv
// Testbench top for the IMU frame parser: clock, reset, byte stream stimulus,
// receiver back-pressure and gain writes; the verdict comes from the checker.
// Depends on ifp_pkg, imu_frame_parser_top and imu_frame_parser_checker.

module tb_top;
   import ifp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;      // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;           // [31:0] axis_x, [63:32] axis_y, [95:64] axis_z
   logic [1:0]  rsp_tuser;           // [1:0] frame_kind
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int failures, pending, frames_checked;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int bytes_sent = 0;
   int phase_start;
   int hold_left = 0;
   bit hold_start = 1'b0;

   imu_frame_parser_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   imu_frame_parser_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .failures(failures), .pending(pending), .frames_checked(frames_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_start) begin
         hold_left = 120;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] head, input logic [7:0] kind_byte,
                             input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                             input logic [7:0] sum_flip);
      logic [7:0]  frame[11];
      logic [15:0] temp;
      logic [7:0]  sum;
      temp = 16'($urandom);
      frame = '{head, kind_byte, x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8],
                temp[7:0], temp[15:8], 8'h00};
      sum = '0;
      for (int i = 0; i < 10; i++)
         sum = sum + frame[i];
      frame[10] = sum ^ sum_flip;
      for (int i = 0; i < 11; i++)
         send_byte(frame[i]);
   endtask

   task automatic write_gain(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_gain_set(input logic [31:0] accel, input logic [31:0] gyro,
                                 input logic [31:0] angle, input logic [31:0] mag);
      write_gain(REG_ACCEL_GAIN, accel);
      write_gain(REG_GYRO_GAIN, gyro);
      write_gain(REG_ANGLE_GAIN, angle);
      write_gain(REG_MAG_GAIN, mag);
   endtask

   // Stop sending and wait out every pending result plus the pipeline depth.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_axis();
      logic [15:0] corners[5];
      corners = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
      if ($urandom_range(3) == 0)
         return corners[$urandom_range(4)];
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] pick_kind_byte();
      logic [7:0] kinds[4];
      kinds = '{KIND_BYTE_A, KIND_BYTE_G, KIND_BYTE_R, KIND_BYTE_M};
      return kinds[$urandom_range(3)];
   endfunction

   task automatic send_random_event();
      int         roll;
      logic [7:0] b;
      roll = $urandom_range(99);
      if (roll < 65) begin
         send_frame(FRAME_HEAD, pick_kind_byte(), pick_axis(), pick_axis(), pick_axis(), 8'h00);
      end else if (roll < 75) begin
         send_frame(FRAME_HEAD, pick_kind_byte(), pick_axis(), pick_axis(), pick_axis(),
                    8'($urandom_range(255, 1)));
      end else if (roll < 82) begin
         do b = 8'($urandom); while (b == FRAME_HEAD);
         send_frame(b, pick_kind_byte(), pick_axis(), pick_axis(), pick_axis(), 8'h00);
      end else if (roll < 89) begin
         do b = 8'($urandom); while (b >= KIND_BYTE_A && b <= KIND_BYTE_M);
         send_frame(FRAME_HEAD, b, pick_axis(), pick_axis(), pick_axis(), 8'h00);
      end else begin
         repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_gain_set(ACCEL_GAIN_RST, GYRO_GAIN_RST, ANGLE_GAIN_RST, MAG_GAIN_RST);

      // Directed: one frame per kind (mag with a bad checksum), axis corners, the fill-up bytes of the first frame.
      send_frame(FRAME_HEAD, KIND_BYTE_A, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h00);
      send_frame(FRAME_HEAD, KIND_BYTE_G, 16'h0000, 16'h0001, 16'h8001, 8'h00);
      send_frame(FRAME_HEAD, KIND_BYTE_M, 16'h8000, 16'h7FFF, 16'h00FF, 8'h01);
      send_frame(FRAME_HEAD, KIND_BYTE_R, 16'hFF00, 16'h5555, 16'hAAAA, 8'h00);

      for (int p = 0; p < 5; p++) begin
         drain();
         case (p)
            0: write_gain_set(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
            1: write_gain_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: write_gain_set($urandom, $urandom, $urandom, $urandom);
            3: write_gain_set(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
            default: write_gain_set(ACCEL_GAIN_RST, GYRO_GAIN_RST, ANGLE_GAIN_RST,
                                    MAG_GAIN_RST);
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 65)
            send_random_event();
      end

      // Hold the result side off while frames keep coming, so the input stalls.
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_start = 1'b1;
      repeat (5)
         send_frame(FRAME_HEAD, pick_kind_byte(), pick_axis(), pick_axis(), pick_axis(), 8'h00);
      drain();

      $display("Run covered %0d bytes and %0d frame results", bytes_sent, frames_checked);
      $display("over five gain settings, four idle patterns and one long receiver hold-off.");
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #3000000;
      $display("Timeout waiting for results");
      $display("Mismatches found");
      $finish;
   end

endmodule
